// ===== hdl/inflight_admission_scoreboard_defines.svh =====
// assertion macros shared by the scoreboard rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef INFLIGHT_ADMISSION_SCOREBOARD_DEFINES_SVH
`define INFLIGHT_ADMISSION_SCOREBOARD_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define IAS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IAS_ASSERT_IMPL(name, ante, cons, msg)
`define IAS_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hdl/ias_pkg.sv =====
// constants and codes for the inflight admission scoreboard
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package ias_pkg;

  localparam int GROUPS = 64;
  localparam int GID_W  = 6;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 2;

  // group ids are only GID_W bits wide, so at most 2**GID_W groups are reachable
  localparam int GRP_DEPTH = (GROUPS < (1 << GID_W)) ? GROUPS : (1 << GID_W);
  localparam int GRP_AW    = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;

  localparam logic [1:0] MODE_QUERY   = 2'd0;
  localparam logic [1:0] MODE_OCCUPY  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] KIND_CPU     = 2'd0;
  localparam logic [1:0] KIND_COMPUTE = 2'd1;
  localparam logic [1:0] KIND_RECV    = 2'd2;
  localparam logic [1:0] KIND_COMM    = 2'd3;

  localparam logic [CFG_W-1:0] CFG_GROUP_CAP     = 2'd0;
  localparam logic [CFG_W-1:0] CFG_UNGROUPED_CAP = 2'd1;
  localparam logic [CFG_W-1:0] CFG_CAP_BYPASS    = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

// ===== hdl/ias_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ias_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/inflight_admission_scoreboard.sv =====
// inflight admission scoreboard top level: cpu/compute busy slots and
// communication counters; uses ias_pkg, ias_ram and the assertion macro header
`timescale 1ns / 1ps
`include "inflight_admission_scoreboard_defines.svh"

// An item is taken when start is high and busy is low. Its result is strobed
// on out_valid for one cycle, through the update stage and the result register,
// and must be captured then: there is no way to stall it. The block takes no
// new item while busy; busy is high in the cycle after each accept while the
// group counter read from the counter RAM (registered read) is updated and
// written back. Group counters start at zero through a valid bit per group, so
// no clearing pass follows reset. Configuration writes are always ready and
// should be issued only while no item is pending.
module inflight_admission_scoreboard
  import ias_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // command channel
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_mode,
  input  logic [1:0]       in_kind,
  input  logic             in_group_valid,
  input  logic [GID_W-1:0] in_group_id,
  // result channel
  output logic             out_valid,
  output logic             out_available,
  output logic             out_violation,
  output logic [CNT_W-1:0] out_class_count,
  // configuration channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  // configuration
  logic [CNT_W-1:0] group_cap_r;
  logic [CNT_W-1:0] ungrouped_cap_r;
  logic             cap_bypass_r;

  // scoreboard state
  logic                 cpu_busy_r, cpu_busy_nxt;
  logic                 comp_busy_r, comp_busy_nxt;
  logic [CNT_W-1:0]     ungrp_cnt_r, ungrp_cnt_nxt;
  logic [GRP_DEPTH-1:0] grp_vld_r;

  // update stage
  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  logic [1:0]        s1_kind_r;
  logic              s1_grouped_r;
  logic [GRP_AW-1:0] s1_idx_r;

  logic              accept;
  logic [1:0]        mode_norm;
  logic              in_grouped;
  logic [CNT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  new_cnt;
  logic              s1_avail;
  logic              s1_viol;
  logic [CNT_W-1:0]  s1_count;
  logic              ram_we;

  // result register
  logic             out_valid_r;
  logic             out_avail_r;
  logic             out_viol_r;
  logic [CNT_W-1:0] out_count_r;

  assign accept    = start && !busy;
  assign busy      = s1_valid_r;
  assign cfg_ready = 1'b1;

  // unused mode code behaves as a query
  assign mode_norm = (in_mode == MODE_OCCUPY || in_mode == MODE_RELEASE) ? in_mode : MODE_QUERY;

  assign in_grouped = in_group_valid && (in_kind == KIND_COMM) &&
                      (32'(in_group_id) < 32'(GRP_DEPTH));

  ias_ram #(
    .WIDTH(CNT_W),
    .DEPTH(GRP_DEPTH)
  ) u_grp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (new_cnt),
    .re    (accept),
    .raddr (in_group_id[GRP_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_cnt = s1_grouped_r ? (grp_vld_r[s1_idx_r] ? ram_rdata : '0) : ungrp_cnt_r;
    cap     = s1_grouped_r ? group_cap_r : ungrouped_cap_r;

    new_cnt       = cur_cnt;
    cpu_busy_nxt  = cpu_busy_r;
    comp_busy_nxt = comp_busy_r;
    s1_avail      = 1'b0;
    s1_viol       = 1'b0;
    s1_count      = '0;

    unique case (s1_kind_r)
      KIND_CPU: begin
        s1_avail = !cpu_busy_r;
        unique case (s1_mode_r)
          MODE_OCCUPY: begin
            if (cpu_busy_r) s1_viol = 1'b1;
            else cpu_busy_nxt = 1'b1;
          end
          MODE_RELEASE: begin
            if (!cpu_busy_r) s1_viol = 1'b1;
            else cpu_busy_nxt = 1'b0;
          end
          default: ;
        endcase
        s1_count = CNT_W'(cpu_busy_nxt);
      end
      KIND_COMPUTE: begin
        s1_avail = !comp_busy_r;
        unique case (s1_mode_r)
          MODE_OCCUPY: begin
            if (comp_busy_r) s1_viol = 1'b1;
            else comp_busy_nxt = 1'b1;
          end
          MODE_RELEASE: begin
            if (!comp_busy_r) s1_viol = 1'b1;
            else comp_busy_nxt = 1'b0;
          end
          default: ;
        endcase
        s1_count = CNT_W'(comp_busy_nxt);
      end
      KIND_RECV: begin
        s1_avail = 1'b1;
      end
      KIND_COMM: begin
        s1_avail = cap_bypass_r || (cur_cnt < cap);
        unique case (s1_mode_r)
          MODE_OCCUPY: begin
            if (cur_cnt == CNT_MAX) s1_viol = 1'b1;
            else new_cnt = cur_cnt + 1'b1;
          end
          MODE_RELEASE: begin
            if (cur_cnt == '0) s1_viol = 1'b1;
            else new_cnt = cur_cnt - 1'b1;
          end
          default: ;
        endcase
        s1_count = new_cnt;
      end
    endcase
  end

  assign ram_we        = s1_valid_r && s1_grouped_r && (new_cnt != cur_cnt);
  assign ungrp_cnt_nxt = (s1_valid_r && (s1_kind_r == KIND_COMM) && !s1_grouped_r) ?
                         new_cnt : ungrp_cnt_r;

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_cap_r     <= CNT_W'(1);
      ungrouped_cap_r <= CNT_W'(1);
      cap_bypass_r    <= 1'b0;
      cpu_busy_r      <= 1'b0;
      comp_busy_r     <= 1'b0;
      ungrp_cnt_r     <= '0;
      grp_vld_r       <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GROUP_CAP:     group_cap_r     <= cfg_data;
          CFG_UNGROUPED_CAP: ungrouped_cap_r <= cfg_data;
          CFG_CAP_BYPASS:    cap_bypass_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (s1_valid_r) begin
        cpu_busy_r  <= cpu_busy_nxt;
        comp_busy_r <= comp_busy_nxt;
      end
      ungrp_cnt_r <= ungrp_cnt_nxt;
      if (ram_we) begin
        grp_vld_r[s1_idx_r] <= 1'b1;
      end
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r    <= mode_norm;
      s1_kind_r    <= in_kind;
      s1_grouped_r <= in_grouped;
      s1_idx_r     <= in_group_id[GRP_AW-1:0];
    end
    if (s1_valid_r) begin
      out_avail_r <= s1_avail;
      out_viol_r  <= s1_viol;
      out_count_r <= s1_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_available   = out_avail_r;
  assign out_violation   = out_viol_r;
  assign out_class_count = out_count_r;

  `IAS_ASSERT_IMPL(a_result_follows, accept, ##2 out_valid, "accepted beat produced no result")
  `IAS_ASSERT_IMPL(a_no_overlap, out_valid, !busy, "result strobed while an item is in update")
  `IAS_ASSERT_NEXT(a_viol_keeps_state, s1_valid_r && s1_viol,
    $stable(cpu_busy_r) && $stable(comp_busy_r) && $stable(ungrp_cnt_r),
    "violation changed scoreboard state")
  `IAS_ASSERT_IMPL(a_recv_free, s1_valid_r && s1_kind_r == KIND_RECV,
    s1_avail && !s1_viol && !ram_we, "receive beat was blocked or changed state")

endmodule

// ===== dv/inflight_admission_scoreboard_test.sv =====
// self-checking testbench for the inflight admission scoreboard: directed and random
// command beats, predicted in place and compared per field; needs ias_pkg and the rtl
`timescale 1ns / 1ps

module inflight_admission_scoreboard_test;
  import ias_pkg::*;

  // the spare mode code behaves as a query
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic             available;
    logic             violation;
    logic [CNT_W-1:0] class_count;
  } admission_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_mode = MODE_QUERY;
  logic [1:0]       in_kind = KIND_CPU;
  logic             in_group_valid = 1'b0;
  logic [GID_W-1:0] in_group_id = '0;
  logic             out_valid;
  logic             out_available;
  logic             out_violation;
  logic [CNT_W-1:0] out_class_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_index = CFG_GROUP_CAP;
  logic [CNT_W-1:0] cfg_data = '0;

  inflight_admission_scoreboard i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_kind         (in_kind),
    .in_group_valid  (in_group_valid),
    .in_group_id     (in_group_id),
    .out_valid       (out_valid),
    .out_available   (out_available),
    .out_violation   (out_violation),
    .out_class_count (out_class_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // shadow copy of the occupancy state and registers
  logic             shadow_cpu_busy;
  logic             shadow_compute_busy;
  logic [CNT_W-1:0] shadow_group_cnt [GROUPS];
  logic [CNT_W-1:0] shadow_ungrouped_cnt;
  logic [CNT_W-1:0] shadow_group_cap;
  logic [CNT_W-1:0] shadow_ungrouped_cap;
  logic             shadow_bypass;

  admission_t       pending_verdicts [$];
  int unsigned      mismatch_count;
  int unsigned      items_sent;
  int unsigned      results_seen;
  int unsigned      violations_seen;
  int unsigned      denials_seen;
  bit               steady_sender;
  logic [GID_W-1:0] group_pool [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_verdicts.size());
    $display("status: fail");
    $finish;
  end

  function automatic admission_t predict_admission(logic [1:0] mode, logic [1:0] kind,
                                                   logic gvalid, logic [GID_W-1:0] gid);
    admission_t       r;
    logic [1:0]       op;
    logic             slot;
    logic             use_group;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cap;
    r = '0;
    op = (mode == MODE_SPARE) ? MODE_QUERY : mode;
    if (kind == KIND_CPU || kind == KIND_COMPUTE) begin
      slot = (kind == KIND_CPU) ? shadow_cpu_busy : shadow_compute_busy;
      r.available = !slot;
      if (op == MODE_OCCUPY) begin
        if (slot) r.violation = 1'b1;
        else slot = 1'b1;
      end else if (op == MODE_RELEASE) begin
        if (!slot) r.violation = 1'b1;
        else slot = 1'b0;
      end
      if (kind == KIND_CPU) shadow_cpu_busy = slot;
      else shadow_compute_busy = slot;
      r.class_count = {{(CNT_W-1){1'b0}}, slot};
    end else if (kind == KIND_RECV) begin
      r.available = 1'b1;
    end else begin
      use_group = gvalid && (int'(gid) < GROUPS);
      cnt = use_group ? shadow_group_cnt[gid] : shadow_ungrouped_cnt;
      cap = use_group ? shadow_group_cap : shadow_ungrouped_cap;
      r.available = shadow_bypass || (cnt < cap);
      if (op == MODE_OCCUPY) begin
        if (cnt == CNT_MAX) r.violation = 1'b1;
        else cnt = cnt + 1'b1;
      end else if (op == MODE_RELEASE) begin
        if (cnt == '0) r.violation = 1'b1;
        else cnt = cnt - 1'b1;
      end
      if (use_group) shadow_group_cnt[gid] = cnt;
      else shadow_ungrouped_cnt = cnt;
      r.class_count = cnt;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    if (mismatch_count < 30)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, want, got);
    mismatch_count++;
  endtask

  // monitor: predicts on each accepted beat, checks each strobed result
  always @(posedge clk) begin
    admission_t want;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (out_violation) violations_seen++;
        if (!out_available) denials_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 1);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_available !== want.available)
            report_mismatch("available", want.available, out_available);
          if (out_violation !== want.violation)
            report_mismatch("violation", want.violation, out_violation);
          if (out_class_count !== want.class_count)
            report_mismatch("class_count", want.class_count, out_class_count);
        end
      end
      if (start && !busy)
        pending_verdicts.push_back(predict_admission(in_mode, in_kind, in_group_valid,
                                                     in_group_id));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GROUP_CAP:     shadow_group_cap = cfg_data;
          CFG_UNGROUPED_CAP: shadow_ungrouped_cap = cfg_data;
          CFG_CAP_BYPASS:    shadow_bypass = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  function automatic int unsigned pick_gap();
    if (steady_sender) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  // drives one command beat and holds it until taken; start stays high on a zero gap
  task automatic send_item(logic [1:0] mode, logic [1:0] kind, logic gvalid,
                           logic [GID_W-1:0] gid);
    int unsigned gap;
    start <= 1'b1;
    in_mode <= mode;
    in_kind <= kind;
    in_group_valid <= gvalid;
    in_group_id <= gid;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_W-1:0] index, logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_queries();
    send_item(MODE_QUERY, KIND_CPU, 1'b1, '1);
    send_item(MODE_QUERY, KIND_COMPUTE, 1'b0, '0);
    send_item(MODE_QUERY, KIND_RECV, 1'b1, 6'd5);
    send_item(MODE_QUERY, KIND_COMM, 1'b1, '0);
    send_item(MODE_QUERY, KIND_COMM, 1'b1, '1);
    send_item(MODE_SPARE, KIND_COMM, 1'b0, 6'd9);
    drain();
  endtask

  task automatic test_busy_slots();
    logic [1:0] k;
    for (int i = 0; i < 2; i++) begin
      k = (i == 0) ? KIND_CPU : KIND_COMPUTE;
      send_item(MODE_OCCUPY, k, 1'b1, 6'($urandom));
      send_item(MODE_OCCUPY, k, 1'b0, 6'($urandom));  // already busy
      send_item(MODE_QUERY, k, 1'b1, 6'($urandom));
      send_item(MODE_RELEASE, k, 1'b1, 6'($urandom));
      send_item(MODE_RELEASE, k, 1'b0, 6'($urandom)); // not in flight
    end
    drain();
  endtask

  task automatic test_comm_caps();
    send_item(MODE_OCCUPY, KIND_COMM, 1'b1, 6'd5);
    send_item(MODE_QUERY, KIND_COMM, 1'b1, 6'd5);    // at cap
    send_item(MODE_OCCUPY, KIND_COMM, 1'b1, 6'd5);   // occupy skips the cap check
    send_item(MODE_QUERY, KIND_COMM, 1'b1, 6'd6);    // other group unaffected
    send_item(MODE_OCCUPY, KIND_COMM, 1'b0, 6'd5);
    send_item(MODE_SPARE, KIND_COMM, 1'b0, 6'd0);
    send_item(MODE_OCCUPY, KIND_RECV, 1'b1, 6'd5);
    send_item(MODE_RELEASE, KIND_RECV, 1'b0, 6'd5);
    send_item(MODE_RELEASE, KIND_COMM, 1'b1, 6'd5);
    send_item(MODE_RELEASE, KIND_COMM, 1'b1, 6'd5);
    send_item(MODE_RELEASE, KIND_COMM, 1'b1, 6'd5);  // counter already zero
    send_item(MODE_RELEASE, KIND_COMM, 1'b0, 6'd5);
    send_item(MODE_RELEASE, KIND_COMM, 1'b0, 6'd5);  // counter already zero
    drain();
    write_reg(CFG_CAP_BYPASS, 8'd1);
    write_reg(CFG_GROUP_CAP, 8'd0);
    send_item(MODE_QUERY, KIND_COMM, 1'b1, 6'd7);    // bypass beats a zero cap
    drain();
    write_reg(CFG_CAP_BYPASS, 8'd0);
    send_item(MODE_QUERY, KIND_COMM, 1'b1, 6'd7);
    drain();
  endtask

  // drives one group counter to the ceiling, then backs it off a little
  task automatic test_counter_ceiling();
    write_reg(CFG_GROUP_CAP, CNT_MAX);
    for (int i = 0; i < 256; i++)
      send_item(MODE_OCCUPY, KIND_COMM, 1'b1, '1);  // last one hits the ceiling and is flagged as a violation
    send_item(MODE_QUERY, KIND_COMM, 1'b1, '1);
    send_item(MODE_RELEASE, KIND_COMM, 1'b1, '1);
    send_item(MODE_RELEASE, KIND_COMM, 1'b1, '1);
    drain();
  endtask

  function automatic logic [CNT_W-1:0] pick_cap();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_MAX;
      2: return CNT_W'($urandom_range(0, 255));
      default: return CNT_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic test_random_traffic(int unsigned phases, int unsigned per_phase);
    int unsigned r;
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic        gvalid;
    for (int p = 0; p < phases; p++) begin
      drain();
      write_reg(CFG_GROUP_CAP, pick_cap());
      write_reg(CFG_UNGROUPED_CAP, pick_cap());
      write_reg(CFG_CAP_BYPASS, {7'd0, 1'($urandom_range(0, 4) == 0)});
      steady_sender = ($urandom_range(0, 3) == 0);
      group_pool[0] = '0;
      group_pool[1] = '1;
      group_pool[2] = 6'($urandom);
      group_pool[3] = 6'($urandom);
      for (int i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 19);
        mode = (r < 6) ? MODE_QUERY : (r < 13) ? MODE_OCCUPY :
               (r < 19) ? MODE_RELEASE : MODE_SPARE;
        r = $urandom_range(0, 9);
        kind = (r < 2) ? KIND_CPU : (r < 4) ? KIND_COMPUTE : (r < 5) ? KIND_RECV : KIND_COMM;
        gvalid = ($urandom_range(0, 3) != 0);
        if (kind == KIND_COMM && $urandom_range(0, 7) != 0)
          send_item(mode, kind, gvalid, group_pool[$urandom_range(0, 3)]);
        else
          send_item(mode, kind, gvalid, 6'($urandom));
      end
    end
    steady_sender = 1'b0;
    drain();
  endtask

  initial begin
    shadow_cpu_busy = 1'b0;
    shadow_compute_busy = 1'b0;
    foreach (shadow_group_cnt[g]) shadow_group_cnt[g] = '0;
    shadow_ungrouped_cnt = '0;
    shadow_group_cap = 8'd1;
    shadow_ungrouped_cap = 8'd1;
    shadow_bypass = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    violations_seen = 0;
    denials_seen = 0;
    steady_sender = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_queries();
    test_busy_slots();
    test_comm_caps();
    test_counter_ceiling();
    test_random_traffic(4, 55);

    drain();
    repeat (6) @(posedge clk);
    $display("covered %0d command beats, %0d results: %0d violations, %0d denials",
             items_sent, results_seen, violations_seen, denials_seen);
    $display("slot rules, cap limits, bypass and a group counter ceiling, random caps");
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               pending_verdicts.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ias_pkg.sv
hdl/ias_ram.sv
hdl/inflight_admission_scoreboard.sv
dv/inflight_admission_scoreboard_test.sv
